// ===== rtl/apd_pkg.sv =====
// apd_pkg: shared types and constants for the adaptive pulse detector
// payload structs, configuration struct, register indexes and reset values
// no dependencies
`default_nettype none

package apd_pkg;

    // configuration register indexes
    localparam int unsigned CfgAddrWidth = 3;
    typedef enum logic [CfgAddrWidth-1:0] {
        REG_VALID_LOW     = 3'd0,
        REG_VALID_HIGH    = 3'd1,
        REG_RECAL_GAP_MS  = 3'd2,
        REG_SETTLE_MS     = 3'd3,
        REG_CALIB_END_MS  = 3'd4,
        REG_REFRACTORY_MS = 3'd5
    } cfg_index_t;

    localparam int unsigned CfgDataWidth = 16;

    // configuration reset values
    localparam logic [9:0]  VALID_LOW_RST     = 10'd850;
    localparam logic [9:0]  VALID_HIGH_RST    = 10'd870;
    localparam logic [15:0] RECAL_GAP_MS_RST  = 16'd2000;
    localparam logic [15:0] SETTLE_MS_RST     = 16'd500;
    localparam logic [15:0] CALIB_END_MS_RST  = 16'd1000;
    localparam logic [15:0] REFRACTORY_MS_RST = 16'd250;

    // running minimum value after a calibration restart
    localparam logic [10:0] RESTART_MIN = 11'd2000;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [9:0]  sample;
    } apd_in_t;

    typedef struct packed {
        logic        pulse;
        logic        calibrated;
        logic [10:0] threshold;
    } apd_out_t;

    typedef struct packed {
        logic [9:0]  valid_low;
        logic [9:0]  valid_high;
        logic [15:0] recal_gap_ms;
        logic [15:0] settle_ms;
        logic [15:0] calib_end_ms;
        logic [15:0] refractory_ms;
    } apd_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/apd_core.sv =====
// apd_core: detector state and per-sample update logic
// computes the next state and the result for one sample combinationally
// depends on apd_pkg
`default_nettype none

module apd_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire apd_pkg::apd_in_t  item,
    input  wire apd_pkg::apd_cfg_t cfg,
    output apd_pkg::apd_out_t      result
);
    import apd_pkg::*;

    logic [31:0] last_detect_reg, last_detect_next;
    logic [31:0] calib_start_reg, calib_start_next;
    logic        pulse_reg, pulse_next;
    logic        calibrated_reg, calibrated_next;
    logic [10:0] threshold_reg, threshold_next;
    logic [10:0] min_reg, min_next;
    logic [9:0]  max_reg, max_next;

    logic [31:0] gap;
    logic [31:0] since;
    logic        sample_ok;
    logic [11:0] mid_sum;

    // wrapping time differences
    assign gap     = item.now_ms - last_detect_reg;
    assign since   = item.now_ms - calib_start_reg;
    assign mid_sum = {2'b00, max_reg} + {1'b0, min_reg};

    assign sample_ok = (item.sample > cfg.valid_low) && (item.sample < cfg.valid_high);

    // next state for one sample
    always_comb begin
        last_detect_next = last_detect_reg;
        calib_start_next = calib_start_reg;
        pulse_next       = pulse_reg;
        calibrated_next  = calibrated_reg;
        threshold_next   = threshold_reg;
        min_next         = min_reg;
        max_next         = max_reg;
        if (!sample_ok) begin
            pulse_next = 1'b0;
        end else if (gap > {16'd0, cfg.recal_gap_ms}) begin
            // restart calibration
            min_next         = RESTART_MIN;
            max_next         = '0;
            calib_start_next = item.now_ms;
            last_detect_next = item.now_ms;
            calibrated_next  = 1'b0;
        end else if (since > {16'd0, cfg.settle_ms}) begin
            if (since <= {16'd0, cfg.calib_end_ms}) begin
                // track min and max
                if ({1'b0, item.sample} < min_reg) begin
                    min_next = {1'b0, item.sample};
                end
                if (item.sample > max_reg) begin
                    max_next = item.sample;
                end
            end else if (!calibrated_reg) begin
                // midpoint plus one
                threshold_next  = mid_sum[11:1] + 11'd1;
                calibrated_next = 1'b1;
            end else if ((gap > {16'd0, cfg.refractory_ms}) &&
                         ({1'b0, item.sample} > threshold_reg)) begin
                last_detect_next = item.now_ms;
                pulse_next       = 1'b1;
            end else begin
                pulse_next = 1'b0;
            end
        end
    end

    // result reflects the state after this sample
    assign result.pulse      = pulse_next;
    assign result.calibrated = calibrated_next;
    assign result.threshold  = threshold_next;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_detect_reg <= '0;
            calib_start_reg <= '0;
            pulse_reg       <= 1'b0;
            calibrated_reg  <= 1'b0;
            threshold_reg   <= '0;
            min_reg         <= RESTART_MIN;
            max_reg         <= '0;
        end else if (step) begin
            last_detect_reg <= last_detect_next;
            calib_start_reg <= calib_start_next;
            pulse_reg       <= pulse_next;
            calibrated_reg  <= calibrated_next;
            threshold_reg   <= threshold_next;
            min_reg         <= min_next;
            max_reg         <= max_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/adaptive_pulse_detector.sv =====
// adaptive_pulse_detector: top level with handshakes and configuration registers
// input register, detector core and result register
// depends on apd_pkg and apd_core
`default_nettype none

// One sample is accepted per transaction and yields exactly one result
// transaction carrying the pulse flag, the calibrated flag and the current
// threshold. The block takes a new sample every clock cycle while the result
// side is not stalled; a result is offered once its sample has passed through
// the input register, loaded when the sample is accepted, and then the result
// register, loaded from the combinational state update. Stalls on the
// result side back up through the input register to s_ready. Configuration
// registers are written through cfg_wr_en/cfg_addr/cfg_wdata,
// keeping only each register's width; addresses above 5 are ignored. Write
// configuration only while no sample is in flight.

module adaptive_pulse_detector (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire apd_pkg::apd_in_t                    s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output apd_pkg::apd_out_t                        m_data,
    input  wire logic                                cfg_wr_en,
    input  wire logic [apd_pkg::CfgAddrWidth-1:0]    cfg_addr,
    input  wire logic [apd_pkg::CfgDataWidth-1:0]    cfg_wdata
);
    import apd_pkg::*;

    apd_cfg_t cfg_reg;
    logic     in_valid_reg;
    apd_in_t  in_data_reg;
    logic     out_valid_reg;
    apd_out_t out_data_reg;
    apd_out_t core_result;
    logic     out_free;
    logic     advance;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.valid_low     <= VALID_LOW_RST;
            cfg_reg.valid_high    <= VALID_HIGH_RST;
            cfg_reg.recal_gap_ms  <= RECAL_GAP_MS_RST;
            cfg_reg.settle_ms     <= SETTLE_MS_RST;
            cfg_reg.calib_end_ms  <= CALIB_END_MS_RST;
            cfg_reg.refractory_ms <= REFRACTORY_MS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_addr))
                REG_VALID_LOW:     cfg_reg.valid_low     <= cfg_wdata[9:0];
                REG_VALID_HIGH:    cfg_reg.valid_high    <= cfg_wdata[9:0];
                REG_RECAL_GAP_MS:  cfg_reg.recal_gap_ms  <= cfg_wdata;
                REG_SETTLE_MS:     cfg_reg.settle_ms     <= cfg_wdata;
                REG_CALIB_END_MS:  cfg_reg.calib_end_ms  <= cfg_wdata;
                REG_REFRACTORY_MS: cfg_reg.refractory_ms <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // handshake control
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    apd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_data_reg),
        .cfg     (cfg_reg),
        .result  (core_result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= core_result;
        end
    end

endmodule

`default_nettype wire
